@@ rtl/assert_macros.svh @@
// Assertion helpers, clocked on clk; reset is rst_n, active low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define PRA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PRA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/pra_pkg.sv @@
package pra_pkg;

    localparam int NUM_PAGES   = 32768;
    localparam int PAGE_SHIFT  = 12;
    localparam int ADDR_W      = 40;
    localparam int CNT_W       = 8;
    localparam int IDX_W       = $clog2(NUM_PAGES);
    localparam int DEPTH_W     = IDX_W + 1;
    localparam int OFF_W       = ADDR_W - PAGE_SHIFT;
    localparam int MODE_W      = 3;
    localparam int STATUS_W    = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;

    localparam logic [ADDR_W-1:0] BASE_RESET = 40'h00_8000_0000;
    localparam logic [ADDR_W-1:0] LOW_RESET  = 40'h00_8000_0000;
    localparam logic [ADDR_W-1:0] TOP_RESET  = 40'h00_8800_0000;

    // request mode codes
    localparam logic [MODE_W-1:0] MODE_ALLOC = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INC   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_QUERY = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SET   = 3'd4;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP  = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_OOM      = 3'd1,
        ST_BADADDR  = 3'd2,
        ST_MAXREF   = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    // classified operation, as handed from front to back
    typedef enum logic [2:0] {
        OP_ALLOC,
        OP_FREE,
        OP_INC,
        OP_QUERY,
        OP_SET,
        OP_BAD,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] idx;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EXEC
    } back_state_t;

endpackage

@@ rtl/pra_ifs.sv @@
interface pra_req_if import pra_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] page_addr;

    modport source (output valid, mode, page_addr, input ready);
    modport sink   (input valid, mode, page_addr, output ready);
endinterface

interface pra_rsp_if import pra_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   alloc_addr;
    logic [CNT_W-1:0]    ref_count;
    logic                page_released;

    modport source (output valid, status, alloc_addr, ref_count, page_released, input ready);
    modport sink   (input valid, status, alloc_addr, ref_count, page_released, output ready);
endinterface

interface pra_cfg_if import pra_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [ADDR_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/pra_front.sv @@
module pra_front import pra_pkg::*;
(
    pra_req_if.sink           req,
    input  logic              clr_busy,
    input  logic [ADDR_W-1:0] base_addr,
    input  logic [ADDR_W-1:0] low_limit,
    input  logic [ADDR_W-1:0] top_addr,
    output logic              push_valid,
    input  logic              push_ready,
    output cmd_t              push_cmd
);

    logic [ADDR_W:0]   diff;
    logic [OFF_W-1:0]  off;
    logic              out_of_pages;
    logic              bad_free;

    // borrow out of the subtract means below base
    assign diff         = {1'b0, req.page_addr} - {1'b0, base_addr};
    assign off          = diff[ADDR_W-1:PAGE_SHIFT];
    assign out_of_pages = diff[ADDR_W] || (off >= OFF_W'(NUM_PAGES));
    assign bad_free     = (req.page_addr[PAGE_SHIFT-1:0] != '0)
                          || (req.page_addr < low_limit)
                          || (req.page_addr >= top_addr);

    always_comb
    begin
        push_cmd.idx = off[IDX_W-1:0];
        unique case (req.mode) inside
            MODE_ALLOC:
                push_cmd.op = OP_ALLOC;
            MODE_FREE:
                push_cmd.op = (out_of_pages || bad_free) ? OP_BAD : OP_FREE;
            MODE_INC, MODE_QUERY, MODE_SET:
            begin
                if (out_of_pages)
                    push_cmd.op = OP_BAD;
                else if (req.mode == MODE_INC)
                    push_cmd.op = OP_INC;
                else if (req.mode == MODE_QUERY)
                    push_cmd.op = OP_QUERY;
                else
                    push_cmd.op = OP_SET;
            end
            default:
                push_cmd.op = OP_NOP;
        endcase
    end

    assign push_valid = req.valid && !clr_busy;
    assign req.ready  = push_ready && !clr_busy;

endmodule

@@ rtl/pra_queue.sv @@
module pra_queue import pra_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop,
    output cmd_t pop_cmd
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

@@ rtl/pra_back.sv @@
module pra_back import pra_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [ADDR_W-1:0] base_addr,
    input  logic              pop_valid,
    output logic              pop,
    input  cmd_t              pop_cmd,
    output logic              clr_busy,
    pra_rsp_if.source         rsp
);

    // page count and free stack storage
    logic [CNT_W-1:0] cnt_mem [NUM_PAGES];
    logic [IDX_W-1:0] stk_mem [NUM_PAGES];
    logic [CNT_W-1:0] cnt_q;
    logic [IDX_W-1:0] stk_q;

    back_state_t       state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [IDX_W-1:0]  clr_reg, clr_next;

    logic              out_valid_reg, out_valid_next;
    status_t           status_reg, status_next;
    logic [ADDR_W-1:0] aaddr_reg, aaddr_next;
    logic [CNT_W-1:0]  rcnt_reg, rcnt_next;
    logic              rel_reg, rel_next;

    logic              cnt_we;
    logic [IDX_W-1:0]  cnt_waddr;
    logic [CNT_W-1:0]  cnt_wdata;
    logic              stk_we;
    logic [IDX_W-1:0]  stk_raddr;
    logic [DEPTH_W-1:0] depth_m1;
    logic [CNT_W-1:0]  dec_cnt;
    logic              out_free;

    assign depth_m1  = depth_reg - 1'b1;
    assign stk_raddr = depth_m1[IDX_W-1:0];
    assign dec_cnt   = (cnt_q != '0) ? cnt_q - 1'b1 : '0;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign clr_busy  = (state_reg == BK_CLEAR);

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        depth_next     = depth_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        status_next    = status_reg;
        aaddr_next     = aaddr_reg;
        rcnt_next      = rcnt_reg;
        rel_next       = rel_reg;
        pop            = 1'b0;
        cnt_we         = 1'b0;
        cnt_waddr      = cmd_reg.idx;
        cnt_wdata      = '0;
        stk_we         = 1'b0;

        unique case (state_reg)
            BK_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(NUM_PAGES - 1))
                    state_next = BK_IDLE;
            end
            BK_IDLE:
            begin
                // reads of count and stack top are issued this cycle
                if (pop_valid && out_free)
                begin
                    pop        = 1'b1;
                    cmd_next   = pop_cmd;
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                state_next     = BK_IDLE;
                out_valid_next = 1'b1;
                status_next    = ST_OK;
                aaddr_next     = '0;
                rcnt_next      = '0;
                rel_next       = 1'b0;
                unique case (cmd_reg.op)
                    OP_ALLOC:
                    begin
                        if (depth_reg == '0)
                            status_next = ST_OOM;
                        else
                        begin
                            depth_next = depth_m1;
                            cnt_we     = 1'b1;
                            cnt_waddr  = stk_q;
                            cnt_wdata  = CNT_W'(1);
                            rcnt_next  = CNT_W'(1);
                            aaddr_next = base_addr
                                + {{(ADDR_W - IDX_W - PAGE_SHIFT){1'b0}},
                                   stk_q, {PAGE_SHIFT{1'b0}}};
                        end
                    end
                    OP_FREE:
                    begin
                        cnt_we    = 1'b1;
                        cnt_wdata = dec_cnt;
                        rcnt_next = dec_cnt;
                        if (dec_cnt == '0)
                        begin
                            if (depth_reg == DEPTH_W'(NUM_PAGES))
                                status_next = ST_OVERFLOW;
                            else
                            begin
                                stk_we     = 1'b1;
                                depth_next = depth_reg + 1'b1;
                                rel_next   = 1'b1;
                            end
                        end
                    end
                    OP_INC:
                    begin
                        if (cnt_q >= COUNT_MAX)
                        begin
                            status_next = ST_MAXREF;
                            rcnt_next   = cnt_q;
                        end
                        else
                        begin
                            cnt_we    = 1'b1;
                            cnt_wdata = cnt_q + 1'b1;
                            rcnt_next = cnt_q + 1'b1;
                        end
                    end
                    OP_QUERY:
                        rcnt_next = cnt_q;
                    OP_SET:
                    begin
                        cnt_we    = 1'b1;
                        cnt_wdata = CNT_W'(1);
                        rcnt_next = CNT_W'(1);
                    end
                    OP_BAD:
                        status_next = ST_BADADDR;
                    default:
                        status_next = ST_OK;
                endcase
            end
            default:
                state_next = BK_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            depth_reg     <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        status_reg <= status_next;
        aaddr_reg  <= aaddr_next;
        rcnt_reg   <= rcnt_next;
        rel_reg    <= rel_next;
    end

    always_ff @(posedge clk)
    begin
        cnt_q <= cnt_mem[pop_cmd.idx];
        if (cnt_we)
            cnt_mem[cnt_waddr] <= cnt_wdata;
    end

    always_ff @(posedge clk)
    begin
        stk_q <= stk_mem[stk_raddr];
        if (stk_we)
            stk_mem[depth_reg[IDX_W-1:0]] <= cmd_reg.idx;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.alloc_addr    = aaddr_reg;
    assign rsp.ref_count     = rcnt_reg;
    assign rsp.page_released = rel_reg;

endmodule

@@ rtl/page_refcount_allocator.sv @@
// Channel   Dir  Payload                                          Transaction
// req       in   mode, page_addr                                  valid & ready
// rsp       out  status, alloc_addr, ref_count, page_released     valid & ready
// cfg       in   index, data (base, low limit, top)               valid & ready
//
// Order: per request, the back reads the page count and free stack top, then
//   executes and loads the result register before it takes the next one.
// Reset: a clearing pass zeroes all 32768 page counts, one per cycle; req is
//   held off until the pass ends, cfg writes are taken throughout.
// Stalls: a 2-entry command queue sits between front and back, so req keeps
//   flowing while a result waits on rsp, until the queue is full.

`include "assert_macros.svh"

module page_refcount_allocator import pra_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    pra_req_if.sink   req,
    pra_rsp_if.source rsp,
    pra_cfg_if.sink   cfg
);

    // Address window registers; the user must write them only while the block is idle; the block does not enforce this.
    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] low_reg;
    logic [ADDR_W-1:0] top_reg;

    // front -> queue -> back
    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop;
    cmd_t pop_cmd;
    logic clr_busy;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BASE_RESET;
            low_reg  <= LOW_RESET;
            top_reg  <= TOP_RESET;
        end
        else if (cfg.valid)
        begin
            // unknown indexes are dropped
            case (cfg.index)
                CFG_BASE: base_reg <= cfg.data;
                CFG_LOW:  low_reg  <= cfg.data;
                CFG_TOP:  top_reg  <= cfg.data;
                default:  ;
            endcase
        end
    end

    // Front: range and alignment checks, page index; bad addresses are
    // turned into a reject command here so the back never writes memory for them.
    pra_front u_front (
        .req        (req),
        .clr_busy   (clr_busy),
        .base_addr  (base_reg),
        .low_limit  (low_reg),
        .top_addr   (top_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    pra_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_cmd    (pop_cmd)
    );

    // Back: count read-modify-write, stack push/pop, result register.
    pra_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .base_addr (base_reg),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_cmd   (pop_cmd),
        .clr_busy  (clr_busy),
        .rsp       (rsp)
    );

    // No result can exist while counts are still being cleared.
    `PRA_ASSERT_ALWAYS(a_no_rsp_in_clear, clr_busy |-> !rsp.valid, "result during clear pass")
    // A released page always comes back with status ok and a zero count.
    `PRA_ASSERT(a_release_ok, (rsp.valid && rsp.page_released) |-> (rsp.status == ST_OK && rsp.ref_count == '0), "bad release result")
    // A nonzero allocation address only comes from a successful allocate.
    `PRA_ASSERT(a_alloc_cnt, (rsp.valid && rsp.alloc_addr != '0) |-> (rsp.status == ST_OK && rsp.ref_count == CNT_W'(1)), "alloc address without count of one")
    // A queued command never waits while the back sits idle with a free output.
    `PRA_ASSERT(a_back_drains, (pop_valid && !clr_busy && !rsp.valid) |-> $past(1'b1) && (pop || $past(pop)), "back ignored queued command")

endmodule
